// ===== rtl/ddpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddpc_pkg
// Shared types and constants of the disk and DMA port controller.
// ----------------------------------------------------------------------------
package ddpc_pkg;

  localparam int PAGE_ENTRIES  = 16;
  localparam int PAGE_IDX_W    = 4;
  localparam int PAGE_OFFSET_W = 12;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [16:0] DMA_SPAN = 17'h10000;

  // I/O port numbers
  localparam logic [7:0] P_PRTS  = 8'd2;
  localparam logic [7:0] P_DRIVE = 8'd10;
  localparam logic [7:0] P_TRKL  = 8'd11;
  localparam logic [7:0] P_TRKH  = 8'd12;
  localparam logic [7:0] P_SECT  = 8'd13;
  localparam logic [7:0] P_CMD   = 8'd14;
  localparam logic [7:0] P_STAT  = 8'd15;
  localparam logic [7:0] P_DMAL  = 8'd16;
  localparam logic [7:0] P_DMAH  = 8'd17;
  localparam logic [7:0] P_PAGEL = 8'd20;
  localparam logic [7:0] P_PAGEH = 8'd21;
  localparam logic [7:0] P_FRAME = 8'd22;
  localparam logic [7:0] P_HALT  = 8'd255;

  // disk status codes
  localparam logic [2:0] STS_OK       = 3'd0;
  localparam logic [2:0] STS_NODRIVE  = 3'd1;
  localparam logic [2:0] STS_NOTRACK  = 3'd2;
  localparam logic [2:0] STS_NOSECTOR = 3'd3;
  localparam logic [2:0] STS_DMAFAIL  = 3'd4;
  localparam logic [2:0] STS_NOCMD    = 3'd7;

  // configuration register indexes
  localparam logic [2:0] CFG_DRIVE_MASK    = 3'd0;
  localparam logic [2:0] CFG_SMALL_TRACKS  = 3'd1;
  localparam logic [2:0] CFG_SMALL_SECTORS = 3'd2;
  localparam logic [2:0] CFG_LARGE_TRACKS  = 3'd3;
  localparam logic [2:0] CFG_LARGE_SECTORS = 3'd4;
  localparam logic [2:0] CFG_SECTOR_BYTES  = 3'd5;
  localparam logic [2:0] CFG_MEM_KB        = 3'd6;

  typedef enum logic [4:0] {
    OP_RD_PRTS,
    OP_RD_DRIVE,
    OP_RD_TRKL,
    OP_RD_TRKH,
    OP_RD_SECT,
    OP_RD_STAT,
    OP_RD_DMAL,
    OP_RD_DMAH,
    OP_RD_NONE,
    OP_WR_DRIVE,
    OP_WR_TRKL,
    OP_WR_TRKH,
    OP_WR_SECT,
    OP_WR_CMD,
    OP_WR_DMAL,
    OP_WR_DMAH,
    OP_WR_PAGEL,
    OP_WR_PAGEH,
    OP_WR_FRAME,
    OP_WR_HALT,
    OP_WR_NONE
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [3:0]  drive_mask;
    logic [15:0] small_tracks;
    logic [7:0]  small_sectors;
    logic [15:0] large_tracks;
    logic [7:0]  large_sectors;
    logic [10:0] sector_bytes;
    logic [18:0] mem_kb;
  } cfg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL1,
    BK_MUL2
  } bk_state_t;

endpackage

// ===== rtl/ddpc_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddpc_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module ddpc_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output ddpc_pkg::cfg_t     cfg
);

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.drive_mask    <= 4'd15;
      cfg.small_tracks  <= 16'd77;
      cfg.small_sectors <= 8'd26;
      cfg.large_tracks  <= 16'd1024;
      cfg.large_sectors <= 8'd32;
      cfg.sector_bytes  <= 11'd128;
      cfg.mem_kb        <= 19'd64;
    end else if (wr_en) begin
      unique case (idx)
        ddpc_pkg::CFG_DRIVE_MASK:    cfg.drive_mask    <= pwdata[3:0];
        ddpc_pkg::CFG_SMALL_TRACKS:  cfg.small_tracks  <= pwdata[15:0];
        ddpc_pkg::CFG_SMALL_SECTORS: cfg.small_sectors <= pwdata[7:0];
        ddpc_pkg::CFG_LARGE_TRACKS:  cfg.large_tracks  <= pwdata[15:0];
        ddpc_pkg::CFG_LARGE_SECTORS: cfg.large_sectors <= pwdata[7:0];
        ddpc_pkg::CFG_SECTOR_BYTES:  cfg.sector_bytes  <= pwdata[10:0];
        ddpc_pkg::CFG_MEM_KB:        cfg.mem_kb        <= pwdata[18:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ddpc_pkg::CFG_DRIVE_MASK:    prdata = {28'd0, cfg.drive_mask};
      ddpc_pkg::CFG_SMALL_TRACKS:  prdata = {16'd0, cfg.small_tracks};
      ddpc_pkg::CFG_SMALL_SECTORS: prdata = {24'd0, cfg.small_sectors};
      ddpc_pkg::CFG_LARGE_TRACKS:  prdata = {16'd0, cfg.large_tracks};
      ddpc_pkg::CFG_LARGE_SECTORS: prdata = {24'd0, cfg.large_sectors};
      ddpc_pkg::CFG_SECTOR_BYTES:  prdata = {21'd0, cfg.sector_bytes};
      ddpc_pkg::CFG_MEM_KB:        prdata = {13'd0, cfg.mem_kb};
      default:                     prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/ddpc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddpc_front
// Request intake: decodes direction and port number into an operation code.
// ----------------------------------------------------------------------------
module ddpc_front (
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [15:0]         s_tdata,   // port[7:0], write_data[15:8]
  input  logic                s_tuser,   // req_type
  output logic                push_valid,
  input  logic                push_ready,
  output ddpc_pkg::item_t     push_item
);

  logic [7:0]    port;
  ddpc_pkg::op_t op;

  assign port = s_tdata[7:0];

  always_comb begin
    if (s_tuser) begin
      unique case (port)
        ddpc_pkg::P_DRIVE: op = ddpc_pkg::OP_WR_DRIVE;
        ddpc_pkg::P_TRKL:  op = ddpc_pkg::OP_WR_TRKL;
        ddpc_pkg::P_TRKH:  op = ddpc_pkg::OP_WR_TRKH;
        ddpc_pkg::P_SECT:  op = ddpc_pkg::OP_WR_SECT;
        ddpc_pkg::P_CMD:   op = ddpc_pkg::OP_WR_CMD;
        ddpc_pkg::P_DMAL:  op = ddpc_pkg::OP_WR_DMAL;
        ddpc_pkg::P_DMAH:  op = ddpc_pkg::OP_WR_DMAH;
        ddpc_pkg::P_PAGEL: op = ddpc_pkg::OP_WR_PAGEL;
        ddpc_pkg::P_PAGEH: op = ddpc_pkg::OP_WR_PAGEH;
        ddpc_pkg::P_FRAME: op = ddpc_pkg::OP_WR_FRAME;
        ddpc_pkg::P_HALT:  op = ddpc_pkg::OP_WR_HALT;
        default:           op = ddpc_pkg::OP_WR_NONE;
      endcase
    end else begin
      unique case (port)
        ddpc_pkg::P_PRTS:  op = ddpc_pkg::OP_RD_PRTS;
        ddpc_pkg::P_DRIVE: op = ddpc_pkg::OP_RD_DRIVE;
        ddpc_pkg::P_TRKL:  op = ddpc_pkg::OP_RD_TRKL;
        ddpc_pkg::P_TRKH:  op = ddpc_pkg::OP_RD_TRKH;
        ddpc_pkg::P_SECT:  op = ddpc_pkg::OP_RD_SECT;
        ddpc_pkg::P_STAT:  op = ddpc_pkg::OP_RD_STAT;
        ddpc_pkg::P_DMAL:  op = ddpc_pkg::OP_RD_DMAL;
        ddpc_pkg::P_DMAH:  op = ddpc_pkg::OP_RD_DMAH;
        default:           op = ddpc_pkg::OP_RD_NONE;
      endcase
    end
  end

  assign push_item.op   = op;
  assign push_item.data = s_tdata[15:8];
  assign push_valid     = s_tvalid;
  assign s_tready       = push_ready;

endmodule

// ===== rtl/ddpc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddpc_queue
// Short FIFO of decoded requests between intake and execution.
// ----------------------------------------------------------------------------
module ddpc_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  ddpc_pkg::item_t     push_item,
  output logic                q_valid,
  input  logic                q_pop,
  output ddpc_pkg::item_t     q_item
);

  localparam int PTR_W = (ddpc_pkg::QUEUE_DEPTH > 1) ? $clog2(ddpc_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(ddpc_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(ddpc_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ddpc_pkg::QUEUE_DEPTH);

  ddpc_pkg::item_t  entries [ddpc_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != FULL_CNT);
  assign q_valid    = (count != '0);
  assign q_item     = entries[rd_ptr];
  assign push       = push_valid & push_ready;
  assign pop        = q_pop & q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== rtl/ddpc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddpc_back
// Execution unit: register file, command checks, offset multiply, result reg.
// ----------------------------------------------------------------------------
module ddpc_back #(
  parameter int NUM_DRIVES = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  ddpc_pkg::cfg_t      cfg,
  input  logic                q_valid,
  output logic                q_pop,
  input  ddpc_pkg::item_t     q_item,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [79:0]         m_tdata,
  output logic                m_tuser
);

  ddpc_pkg::bk_state_t state, state_next;

  logic [1:0]  sel_drive, sel_drive_next;
  logic [15:0] sel_track, sel_track_next;
  logic [7:0]  sel_sector, sel_sector_next;
  logic [2:0]  disk_status, disk_status_next;
  logic [15:0] dma_addr, dma_addr_next;
  logic [15:0] page_select, page_select_next;
  logic [15:0] page_map [ddpc_pkg::PAGE_ENTRIES];

  logic        pm_we;

  logic [24:0] prod, prod_next;
  logic        pend_write, pend_write_next;
  logic [27:0] pend_addr, pend_addr_next;

  logic        out_valid, out_valid_next;
  logic [7:0]  out_rd, out_rd_next;
  logic        out_xv, out_xv_next;
  logic        out_xw, out_xw_next;
  logic [1:0]  out_drive, out_drive_next;
  logic [33:0] out_off, out_off_next;
  logic [27:0] out_addr, out_addr_next;
  logic        out_halt, out_halt_next;

  logic [15:0] tracks;
  logic [7:0]  sectors;
  logic        cmd_drive_ok;
  logic        new_drive_ok;
  logic        frame_ok;
  logic        dma_over;
  logic [24:0] mul_a;
  logic [24:0] mul_b;
  logic [35:0] off_full;
  logic [7:0]  b;

  assign b        = q_item.data;
  assign tracks   = sel_drive[1] ? cfg.large_tracks  : cfg.small_tracks;
  assign sectors  = sel_drive[1] ? cfg.large_sectors : cfg.small_sectors;
  assign cmd_drive_ok = (32'(sel_drive) < NUM_DRIVES) && cfg.drive_mask[sel_drive];
  assign new_drive_ok = (32'(b) < NUM_DRIVES) && (b < 8'd4) && cfg.drive_mask[b[1:0]];
  assign frame_ok = (b < 8'(ddpc_pkg::PAGE_ENTRIES)) &&
                    ({1'b0, page_select, 2'b00} < cfg.mem_kb);
  assign dma_over = (17'(dma_addr) + 17'(cfg.sector_bytes)) > ddpc_pkg::DMA_SPAN;
  assign mul_a    = 25'(sel_track);
  assign mul_b    = 25'(sectors);
  assign off_full = 36'(prod) * 36'(cfg.sector_bytes);

  always_comb begin
    state_next       = state;
    sel_drive_next   = sel_drive;
    sel_track_next   = sel_track;
    sel_sector_next  = sel_sector;
    disk_status_next = disk_status;
    dma_addr_next    = dma_addr;
    page_select_next = page_select;
    pm_we            = 1'b0;
    prod_next        = prod;
    pend_write_next  = pend_write;
    pend_addr_next   = pend_addr;
    q_pop            = 1'b0;
    out_valid_next   = out_valid & ~m_tready;
    out_rd_next      = out_rd;
    out_xv_next      = out_xv;
    out_xw_next      = out_xw;
    out_drive_next   = out_drive;
    out_off_next     = out_off;
    out_addr_next    = out_addr;
    out_halt_next    = out_halt;

    unique case (state)
      ddpc_pkg::BK_IDLE: begin
        if (q_valid && (!out_valid || m_tready)) begin
          q_pop          = 1'b1;
          out_valid_next = 1'b1;
          out_rd_next    = 8'd0;
          out_xv_next    = 1'b0;
          out_xw_next    = 1'b0;
          out_drive_next = 2'd0;
          out_off_next   = 34'd0;
          out_addr_next  = 28'd0;
          out_halt_next  = 1'b0;
          unique case (q_item.op)
            ddpc_pkg::OP_RD_PRTS:  out_rd_next = 8'hff;
            ddpc_pkg::OP_RD_DRIVE: out_rd_next = {6'd0, sel_drive};
            ddpc_pkg::OP_RD_TRKL:  out_rd_next = sel_track[7:0];
            ddpc_pkg::OP_RD_TRKH:  out_rd_next = sel_track[15:8];
            ddpc_pkg::OP_RD_SECT:  out_rd_next = sel_sector;
            ddpc_pkg::OP_RD_STAT:  out_rd_next = {5'd0, disk_status};
            ddpc_pkg::OP_RD_DMAL:  out_rd_next = dma_addr[7:0];
            ddpc_pkg::OP_RD_DMAH:  out_rd_next = dma_addr[15:8];
            ddpc_pkg::OP_WR_DRIVE: begin
              if (new_drive_ok) begin
                sel_drive_next   = b[1:0];
                disk_status_next = ddpc_pkg::STS_OK;
              end else begin
                disk_status_next = ddpc_pkg::STS_NODRIVE;
              end
            end
            ddpc_pkg::OP_WR_TRKL:  sel_track_next   = {sel_track[15:8], b};
            ddpc_pkg::OP_WR_TRKH:  sel_track_next   = {b, sel_track[7:0]};
            ddpc_pkg::OP_WR_SECT:  sel_sector_next  = b;
            ddpc_pkg::OP_WR_DMAL:  dma_addr_next    = {dma_addr[15:8], b};
            ddpc_pkg::OP_WR_DMAH:  dma_addr_next    = {b, dma_addr[7:0]};
            ddpc_pkg::OP_WR_PAGEL: page_select_next = {page_select[15:8], b};
            ddpc_pkg::OP_WR_PAGEH: page_select_next = {b, page_select[7:0]};
            ddpc_pkg::OP_WR_FRAME: pm_we = frame_ok;
            ddpc_pkg::OP_WR_HALT:  out_halt_next = 1'b1;
            ddpc_pkg::OP_WR_CMD: begin
              priority if (!cmd_drive_ok) begin
                disk_status_next = ddpc_pkg::STS_NODRIVE;
              end else if (sel_track >= tracks) begin
                disk_status_next = ddpc_pkg::STS_NOTRACK;
              end else if (sel_sector == 8'd0 || sel_sector > sectors) begin
                disk_status_next = ddpc_pkg::STS_NOSECTOR;
              end else if (dma_over) begin
                disk_status_next = ddpc_pkg::STS_DMAFAIL;
              end else if (b > 8'd1) begin
                disk_status_next = ddpc_pkg::STS_NOCMD;
              end else begin
                disk_status_next = ddpc_pkg::STS_OK;
                out_valid_next   = 1'b0;
                pend_write_next  = b[0];
                pend_addr_next   = {page_map[dma_addr[15:12]],
                                    dma_addr[ddpc_pkg::PAGE_OFFSET_W-1:0]};
                state_next       = ddpc_pkg::BK_MUL1;
              end
            end
            default: ;
          endcase
        end
      end
      ddpc_pkg::BK_MUL1: begin
        // track * sectors + sector - 1; sector is at least one here
        prod_next  = mul_a * mul_b + 25'(sel_sector) - 25'd1;
        state_next = ddpc_pkg::BK_MUL2;
      end
      ddpc_pkg::BK_MUL2: begin
        out_valid_next = 1'b1;
        out_rd_next    = 8'd0;
        out_xv_next    = 1'b1;
        out_xw_next    = pend_write;
        out_drive_next = sel_drive;
        out_off_next   = off_full[33:0];
        out_addr_next  = pend_addr;
        out_halt_next  = 1'b0;
        state_next     = ddpc_pkg::BK_IDLE;
      end
      default: state_next = ddpc_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ddpc_pkg::BK_IDLE;
      sel_drive   <= 2'd0;
      sel_track   <= 16'd0;
      sel_sector  <= 8'd0;
      disk_status <= ddpc_pkg::STS_OK;
      dma_addr    <= 16'd0;
      page_select <= 16'd0;
      out_valid   <= 1'b0;
      for (int i = 0; i < ddpc_pkg::PAGE_ENTRIES; i++) begin
        page_map[i] <= 16'(i);
      end
    end else begin
      state       <= state_next;
      sel_drive   <= sel_drive_next;
      sel_track   <= sel_track_next;
      sel_sector  <= sel_sector_next;
      disk_status <= disk_status_next;
      dma_addr    <= dma_addr_next;
      page_select <= page_select_next;
      out_valid   <= out_valid_next;
      if (pm_we) begin
        page_map[b[ddpc_pkg::PAGE_IDX_W-1:0]] <= page_select;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod       <= prod_next;
    pend_write <= pend_write_next;
    pend_addr  <= pend_addr_next;
    out_rd     <= out_rd_next;
    out_xv     <= out_xv_next;
    out_xw     <= out_xw_next;
    out_drive  <= out_drive_next;
    out_off    <= out_off_next;
    out_addr   <= out_addr_next;
    out_halt   <= out_halt_next;
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_xv;
  assign m_tdata  = {6'd0, out_halt, out_addr, out_off, out_drive, out_xw, out_rd};

endmodule

// ===== rtl/disk_dma_port_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// disk_dma_port_controller
// Disk and DMA I/O port controller with page-mapped sector transfers.
// ----------------------------------------------------------------------------
// Usage: port requests enter on the s_ stream (s_tuser = direction, s_tdata =
// port and data byte); every request gives one result on the m_ stream
// (m_tuser marks an issued sector transfer). The user must set geometry, drive
// mask and memory size through the APB-style port only while no request is in
// flight; the block itself does not enforce this. Path: an accepted request is
// queued, then executed and its result registered; a passing read/write command
// goes through BK_MUL1 (track*sectors+sector-1) and BK_MUL2 (times sector_bytes).
// Throughput: one request per cycle while m_tready allows, except transfer
// commands, which hold the execution unit through BK_MUL1 and BK_MUL2. A
// two-entry request queue lets intake run ahead of execution.
// Reset: drive, track, sector, DMA address, page select and status clear,
// the page table returns to identity mapping, configuration to defaults.
// Stall: while m_tready is low the result holds, execution stops and the
// queue fills; s_tready drops once it is full.
// ----------------------------------------------------------------------------
module disk_dma_port_controller #(
  parameter int NUM_DRIVES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // port[7:0], write_data[15:8]
  input  logic        s_tuser,   // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  // read_data[7:0], xfer_write[8], xfer_drive[10:9], xfer_byte_offset[44:11],
  // xfer_mem_addr[72:45], halt[73], zero[79:74]
  output logic [79:0] m_tdata,
  output logic        m_tuser    // xfer_valid
);

  ddpc_pkg::cfg_t  cfg;
  ddpc_pkg::item_t push_item;
  ddpc_pkg::item_t q_item;
  logic            push_valid;
  logic            push_ready;
  logic            q_valid;
  logic            q_pop;

  ddpc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ddpc_front u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  ddpc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_item     (q_item)
  );

  ddpc_back #(
    .NUM_DRIVES (NUM_DRIVES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  a_pop_ok: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid && (!m_tvalid || m_tready))
    else $error("request taken without item or with result register busy");

  a_xfer_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[7:0] == 8'd0 && !m_tdata[73])
    else $error("transfer result carries read data or halt");

  a_noxfer_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[72:8] == 65'd0)
    else $error("transfer fields nonzero without a transfer");

endmodule

// ===== bench/tb_disk_dma_port_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_disk_dma_port_controller
// Self-checking bench for the disk and DMA port controller. A queue of port
// requests feeds a stream driver; every accepted request runs through a local
// copy of the register file, the page table and the command checks, and the
// resulting read byte and transfer fields are compared with each result the
// block returns. Geometry, drive mask and memory size change over the APB port
// between phases; both streams stall at random through phase four.
// ----------------------------------------------------------------------------
module tb_disk_dma_port_controller;

  localparam int NUM_DRIVES  = 4;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic       is_write;
    logic [7:0] port;
    logic [7:0] data;
  } port_req_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        xfer_valid;
    logic        xfer_write;
    logic [1:0]  xfer_drive;
    logic [33:0] byte_offset;
    logic [27:0] mem_addr;
    logic        halt;
  } port_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // port[7:0], write_data[15:8]
  logic        s_tuser = 1'b0; // req_type
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;        // read_data, xfer_write, xfer_drive, offset, mem_addr, halt
  logic        m_tuser;        // xfer_valid

  disk_dma_port_controller #(.NUM_DRIVES(NUM_DRIVES)) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow copy of configuration and controller state
  ddpc_pkg::cfg_t cfg;
  logic [1:0]  cur_drive;
  logic [15:0] cur_track;
  logic [7:0]  cur_sector;
  logic [2:0]  cur_status;
  logic [15:0] cur_dma;
  logic [15:0] cur_page;
  logic [15:0] page_table [ddpc_pkg::PAGE_ENTRIES];

  port_req_t    pending_reqs [$];
  port_result_t expected_results [$];

  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_count = 0;
  int accepted_count = 0;
  int checked_count = 0;
  int xfer_count = 0;
  int halt_count = 0;
  int gen_count = 0;
  int setting_count = 0;

  function automatic bit drive_present(logic [7:0] d);
    return (d < NUM_DRIVES) && (d < 4) && cfg.drive_mask[d[1:0]];
  endfunction

  function automatic port_result_t predict_access(logic is_write, logic [7:0] port,
                                                  logic [7:0] b);
    port_result_t r;
    logic [15:0]  tracks;
    logic [7:0]   sectors;
    logic [63:0]  off;
    r = '0;
    if (!is_write) begin
      case (port)
        ddpc_pkg::P_PRTS:  r.read_data = 8'hff;
        ddpc_pkg::P_DRIVE: r.read_data = {6'b0, cur_drive};
        ddpc_pkg::P_TRKL:  r.read_data = cur_track[7:0];
        ddpc_pkg::P_TRKH:  r.read_data = cur_track[15:8];
        ddpc_pkg::P_SECT:  r.read_data = cur_sector;
        ddpc_pkg::P_STAT:  r.read_data = {5'b0, cur_status};
        ddpc_pkg::P_DMAL:  r.read_data = cur_dma[7:0];
        ddpc_pkg::P_DMAH:  r.read_data = cur_dma[15:8];
        default: r.read_data = 8'h00;
      endcase
      return r;
    end
    case (port)
      ddpc_pkg::P_DRIVE: begin
        if (drive_present(b)) begin
          cur_drive = b[1:0];
          cur_status = ddpc_pkg::STS_OK;
        end else begin
          cur_status = ddpc_pkg::STS_NODRIVE;
        end
      end
      ddpc_pkg::P_TRKL:  cur_track[7:0] = b;
      ddpc_pkg::P_TRKH:  cur_track[15:8] = b;
      ddpc_pkg::P_SECT:  cur_sector = b;
      ddpc_pkg::P_DMAL:  cur_dma[7:0] = b;
      ddpc_pkg::P_DMAH:  cur_dma[15:8] = b;
      ddpc_pkg::P_PAGEL: cur_page[7:0] = b;
      ddpc_pkg::P_PAGEH: cur_page[15:8] = b;
      ddpc_pkg::P_FRAME: begin
        if (b < ddpc_pkg::PAGE_ENTRIES && {cur_page, 2'b00} < cfg.mem_kb)
          page_table[b[3:0]] = cur_page;
      end
      ddpc_pkg::P_HALT:  r.halt = 1'b1;
      ddpc_pkg::P_CMD: begin
        if (cur_drive < 2) begin
          tracks = cfg.small_tracks;
          sectors = cfg.small_sectors;
        end else begin
          tracks = cfg.large_tracks;
          sectors = cfg.large_sectors;
        end
        if (!drive_present({6'b0, cur_drive})) begin
          cur_status = ddpc_pkg::STS_NODRIVE;
        end else if (cur_track >= tracks) begin
          cur_status = ddpc_pkg::STS_NOTRACK;
        end else if (cur_sector == 0 || cur_sector > sectors) begin
          cur_status = ddpc_pkg::STS_NOSECTOR;
        end else if ({1'b0, cur_dma} + cfg.sector_bytes > ddpc_pkg::DMA_SPAN) begin
          cur_status = ddpc_pkg::STS_DMAFAIL;
        end else if (b > 1) begin
          cur_status = ddpc_pkg::STS_NOCMD;
        end else begin
          off = (64'(cur_track) * 64'(sectors) + 64'(cur_sector) - 64'd1)
                * 64'(cfg.sector_bytes);
          cur_status = ddpc_pkg::STS_OK;
          r.xfer_valid = 1'b1;
          r.xfer_write = b[0];
          r.xfer_drive = cur_drive;
          r.byte_offset = off[33:0];
          r.mem_addr = {page_table[cur_dma[15:12]], cur_dma[11:0]};
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic bit idle_now(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // request driver
  always @(posedge clk) begin : drv
    port_req_t rq;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(predict_access(s_tuser, s_tdata[7:0], s_tdata[15:8]));
        accepted_count++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_reqs.size() > 0 && !idle_now(send_idle_pct)) begin
          rq = pending_reqs.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= rq.is_write;
          s_tdata <= {rq.data, rq.port};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [33:0] want, logic [33:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      error_count++;
    end
  endtask

  // result monitor
  always @(posedge clk) begin : mon
    port_result_t e;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= !idle_now(recv_idle_pct);
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding");
          error_count++;
        end else begin
          e = expected_results.pop_front();
          checked_count++;
          if (e.xfer_valid) xfer_count++;
          if (e.halt) halt_count++;
          check_field("read_data", 34'(e.read_data), 34'(m_tdata[7:0]));
          check_field("xfer_valid", 34'(e.xfer_valid), 34'(m_tuser));
          check_field("xfer_write", 34'(e.xfer_write), 34'(m_tdata[8]));
          check_field("xfer_drive", 34'(e.xfer_drive), 34'(m_tdata[10:9]));
          check_field("xfer_byte_offset", e.byte_offset, m_tdata[44:11]);
          check_field("xfer_mem_addr", 34'(e.mem_addr), 34'(m_tdata[72:45]));
          check_field("halt", 34'(e.halt), 34'(m_tdata[73]));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_disk_dma_port_controller: done, errors");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      ddpc_pkg::CFG_DRIVE_MASK:    cfg.drive_mask = val[3:0];
      ddpc_pkg::CFG_SMALL_TRACKS:  cfg.small_tracks = val[15:0];
      ddpc_pkg::CFG_SMALL_SECTORS: cfg.small_sectors = val[7:0];
      ddpc_pkg::CFG_LARGE_TRACKS:  cfg.large_tracks = val[15:0];
      ddpc_pkg::CFG_LARGE_SECTORS: cfg.large_sectors = val[7:0];
      ddpc_pkg::CFG_SECTOR_BYTES:  cfg.sector_bytes = val[10:0];
      ddpc_pkg::CFG_MEM_KB:        cfg.mem_kb = val[18:0];
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(ddpc_pkg::cfg_t c);
    write_reg(ddpc_pkg::CFG_DRIVE_MASK, 32'(c.drive_mask));
    write_reg(ddpc_pkg::CFG_SMALL_TRACKS, 32'(c.small_tracks));
    write_reg(ddpc_pkg::CFG_SMALL_SECTORS, 32'(c.small_sectors));
    write_reg(ddpc_pkg::CFG_LARGE_TRACKS, 32'(c.large_tracks));
    write_reg(ddpc_pkg::CFG_LARGE_SECTORS, 32'(c.large_sectors));
    write_reg(ddpc_pkg::CFG_SECTOR_BYTES, 32'(c.sector_bytes));
    write_reg(ddpc_pkg::CFG_MEM_KB, 32'(c.mem_kb));
    setting_count++;
  endtask

  task automatic add_req(logic is_write, logic [7:0] port, logic [7:0] data);
    port_req_t rq;
    rq.is_write = is_write;
    rq.port = port;
    rq.data = data;
    pending_reqs.push_back(rq);
    gen_count++;
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // drive select, track, sector, DMA address and a command, mostly in range
  task automatic gen_transfer();
    int d, tracks, sectors, trk, sec, dma, top;
    d = $urandom_range(0, 3);
    repeat (3) if (!cfg.drive_mask[d]) d = $urandom_range(0, 3);
    if ($urandom_range(0, 9) < 8) add_req(1'b1, ddpc_pkg::P_DRIVE, 8'(d));
    else if ($urandom_range(0, 1))
      add_req(1'b1, ddpc_pkg::P_DRIVE, 8'($urandom_range(4, 255)));
    tracks = (d < 2) ? int'(cfg.small_tracks) : int'(cfg.large_tracks);
    sectors = (d < 2) ? int'(cfg.small_sectors) : int'(cfg.large_sectors);
    if ($urandom_range(0, 99) < 85) trk = $urandom_range(0, tracks - 1);
    else trk = $urandom_range(tracks, 65535);
    if ($urandom_range(0, 9) < 8) add_req(1'b1, ddpc_pkg::P_TRKL, 8'(trk));
    if ($urandom_range(0, 9) < 7) add_req(1'b1, ddpc_pkg::P_TRKH, 8'(trk >> 8));
    if ($urandom_range(0, 99) < 85) sec = $urandom_range(1, sectors);
    else if (sectors == 255 || $urandom_range(0, 1)) sec = 0;
    else sec = $urandom_range(sectors + 1, 255);
    if ($urandom_range(0, 9) < 8) add_req(1'b1, ddpc_pkg::P_SECT, 8'(sec));
    top = 65536 - int'(cfg.sector_bytes);
    if ($urandom_range(0, 99) < 85) dma = $urandom_range(0, top);
    else dma = $urandom_range(top, 65535);
    if ($urandom_range(0, 9) < 8) add_req(1'b1, ddpc_pkg::P_DMAL, 8'(dma));
    if ($urandom_range(0, 9) < 8) add_req(1'b1, ddpc_pkg::P_DMAH, 8'(dma >> 8));
    if ($urandom_range(0, 99) < 85)
      add_req(1'b1, ddpc_pkg::P_CMD, 8'($urandom_range(0, 1)));
    else add_req(1'b1, ddpc_pkg::P_CMD, 8'($urandom_range(2, 255)));
    if ($urandom_range(0, 1)) add_req(1'b0, ddpc_pkg::P_STAT, 8'($urandom));
  endtask

  task automatic gen_page_map();
    int pages, pg;
    pages = (int'(cfg.mem_kb) + 3) / 4;
    if ($urandom_range(0, 99) < 85 || pages > 65535) pg = $urandom_range(0, pages - 1);
    else pg = $urandom_range(pages, 65535);
    add_req(1'b1, ddpc_pkg::P_PAGEL, 8'(pg));
    add_req(1'b1, ddpc_pkg::P_PAGEH, 8'(pg >> 8));
    if ($urandom_range(0, 99) < 85)
      add_req(1'b1, ddpc_pkg::P_FRAME, 8'($urandom_range(0, 15)));
    else add_req(1'b1, ddpc_pkg::P_FRAME, 8'($urandom_range(16, 255)));
    if ($urandom_range(0, 1)) gen_transfer();
  endtask

  task automatic gen_random(int n);
    logic [7:0] rd_ports [10];
    int pick;
    rd_ports = '{ddpc_pkg::P_PRTS, ddpc_pkg::P_DRIVE, ddpc_pkg::P_TRKL,
                 ddpc_pkg::P_TRKH, ddpc_pkg::P_SECT, ddpc_pkg::P_STAT,
                 ddpc_pkg::P_DMAL, ddpc_pkg::P_DMAH, ddpc_pkg::P_CMD,
                 ddpc_pkg::P_FRAME};
    gen_count = 0;
    while (gen_count < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) gen_transfer();
      else if (pick < 70) gen_page_map();
      else if (pick < 85) add_req(1'b0, rd_ports[$urandom_range(0, 9)], 8'($urandom));
      else add_req(1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic gen_directed();
    add_req(1'b0, ddpc_pkg::P_PRTS, 8'h00);
    add_req(1'b0, ddpc_pkg::P_STAT, 8'hff);
    add_req(1'b1, ddpc_pkg::P_DRIVE, 8'd4);    // drive index out of range
    add_req(1'b0, ddpc_pkg::P_STAT, 8'h00);
    add_req(1'b1, ddpc_pkg::P_DRIVE, 8'd3);
    add_req(1'b0, ddpc_pkg::P_DRIVE, 8'h00);
    add_req(1'b1, ddpc_pkg::P_TRKL, 8'hff);
    add_req(1'b1, ddpc_pkg::P_TRKH, 8'h03);
    add_req(1'b1, ddpc_pkg::P_SECT, 8'd0);
    add_req(1'b1, ddpc_pkg::P_CMD, 8'd0);      // sector zero
    add_req(1'b1, ddpc_pkg::P_SECT, 8'd32);
    add_req(1'b1, ddpc_pkg::P_DMAH, 8'hff);
    add_req(1'b1, ddpc_pkg::P_DMAL, 8'h81);
    add_req(1'b1, ddpc_pkg::P_CMD, 8'd1);      // DMA overrun
    add_req(1'b1, ddpc_pkg::P_DMAH, 8'h7f);
    add_req(1'b1, ddpc_pkg::P_CMD, 8'd2);      // unknown command
    add_req(1'b1, ddpc_pkg::P_CMD, 8'd1);
    add_req(1'b1, ddpc_pkg::P_PAGEL, 8'd16);
    add_req(1'b1, ddpc_pkg::P_FRAME, 8'd7);    // page beyond memory
    add_req(1'b1, ddpc_pkg::P_PAGEL, 8'd15);
    add_req(1'b1, ddpc_pkg::P_FRAME, 8'd16);   // frame index outside table
    add_req(1'b1, ddpc_pkg::P_FRAME, 8'd7);
    add_req(1'b1, ddpc_pkg::P_CMD, 8'd0);
    add_req(1'b1, ddpc_pkg::P_TRKH, 8'hff);
    add_req(1'b1, ddpc_pkg::P_CMD, 8'd0);      // track past end
    add_req(1'b0, ddpc_pkg::P_TRKH, 8'h00);
    add_req(1'b0, ddpc_pkg::P_DMAL, 8'h00);
    add_req(1'b0, ddpc_pkg::P_HALT, 8'h00);
    add_req(1'b1, ddpc_pkg::P_HALT, 8'h5a);
  endtask

  initial begin : stim
    ddpc_pkg::cfg_t s;
    int   n;
    cfg = '{drive_mask: 4'd15, small_tracks: 16'd77, small_sectors: 8'd26,
            large_tracks: 16'd1024, large_sectors: 8'd32, sector_bytes: 11'd128,
            mem_kb: 19'd64};
    cur_drive = '0;
    cur_track = '0;
    cur_sector = '0;
    cur_status = ddpc_pkg::STS_OK;
    cur_dma = '0;
    cur_page = '0;
    for (int i = 0; i < ddpc_pkg::PAGE_ENTRIES; i++) page_table[i] = 16'(i);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct <= 34;
    recv_idle_pct <= 84;
    gen_directed();
    wait_drained();

    for (int ph = 1; ph <= 7; ph++) begin
      n = 300;
      case (ph)
        1: s = '{4'd15, 16'($urandom_range(1, 300)), 8'($urandom_range(1, 64)),
                 16'($urandom_range(1, 2048)), 8'($urandom_range(1, 64)),
                 11'($urandom_range(1, 1024)), 19'($urandom_range(4, 1024))};
        2: s = '{4'd15, 16'd65535, 8'd255, 16'd65535, 8'd255, 11'd1024, 19'd262144};
        3: s = '{4'd1, 16'd1, 8'd1, 16'd1, 8'd1, 11'd1, 19'd4};
        4: s = '{4'($urandom_range(0, 15)), 16'($urandom_range(1, 65535)),
                 8'($urandom_range(1, 255)), 16'($urandom_range(1, 65535)),
                 8'($urandom_range(1, 255)), 11'($urandom_range(1, 1024)),
                 19'($urandom_range(4, 262144))};
        5: s = '{4'($urandom_range(1, 15)), 16'($urandom_range(1, 16)),
                 8'($urandom_range(1, 8)), 16'($urandom_range(1, 16)),
                 8'($urandom_range(1, 8)), 11'($urandom_range(1, 64)),
                 19'($urandom_range(4, 128))};
        6: s = '{4'd12, 16'd65535, 8'd255, 16'd1, 8'd1, 11'd1024, 19'd4};
        default: begin
          s = '{4'd0, 16'($urandom_range(1, 65535)), 8'($urandom_range(1, 255)),
                16'($urandom_range(1, 65535)), 8'($urandom_range(1, 255)),
                11'($urandom_range(1, 1024)), 19'($urandom_range(4, 262144))};
          n = 150;
        end
      endcase
      apply_setting(s);
      if (ph <= 2) begin
        send_idle_pct <= 34;
        recv_idle_pct <= 84;
      end else if (ph <= 4) begin
        send_idle_pct <= 84;
        recv_idle_pct <= 34;
      end else begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
      gen_random(n);
      wait_drained();
    end

    repeat (16) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d results never returned", expected_results.size());
      error_count++;
    end
    $display("%0d port requests, %0d results checked, %0d register settings",
             accepted_count, checked_count, setting_count);
    $display("%0d sector transfers and %0d halts seen, %0d mismatches",
             xfer_count, halt_count, error_count);
    if (error_count == 0) begin
      $display("tb_disk_dma_port_controller: done, clean");
    end else begin
      $display("tb_disk_dma_port_controller: done, errors");
    end
    $finish;
  end

endmodule

// ===== disk_dma_port_controller.f =====
rtl/ddpc_pkg.sv
rtl/ddpc_regs.sv
rtl/ddpc_front.sv
rtl/ddpc_queue.sv
rtl/ddpc_back.sv
rtl/disk_dma_port_controller.sv
bench/tb_disk_dma_port_controller.sv
